/* rtl/assert_macros.svh */
// assertion macros shared by the hysteresis threshold rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hth_pkg.sv */
// shared types, constants and helpers of the hysteresis threshold block
// no dependencies
package hth_pkg;

  // default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // register reset values
  localparam logic [15:0] HIGH_THR_RST     = 16'd45875;
  localparam logic [15:0] LOW_THR_RST      = 16'd19661;
  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

  // field widths
  localparam int PIXEL_W      = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int FWIDTH_W     = 11;
  localparam int FHEIGHT_W    = 13;
  localparam int OUT_TDATA_W  = 8;
  localparam int CLS_W        = 2;
  localparam int LS_WORD_W    = 2 * CLS_W;

  // output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_THR     = 2'd0,
    REG_LOW_THR      = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_idx_e;

  // class codes kept in the line store and window
  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_WEAK   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_STRONG = 2'd2;

  // per item flags carried from the accept stage to the window stage
  typedef struct packed {
    logic emit;
    logic col_first;
    logic col_last;
    logic row_first;
    logic row_last;
  } s1_ctrl_t;

  // one result item
  typedef struct packed {
    logic frame_end;
    logic edge_on;
  } result_t;

  function automatic logic [CLS_W-1:0] classify(input logic [PIXEL_W-1:0] pix,
                                                input logic [PIXEL_W-1:0] hi,
                                                input logic [PIXEL_W-1:0] lo);
    logic [CLS_W-1:0] cls;
    if (pix > hi) begin
      cls = CLS_STRONG;
    end else if (pix > lo) begin
      cls = CLS_WEAK;
    end else begin
      cls = CLS_NONE;
    end
    return cls;
  endfunction

  function automatic logic is_strong(input logic [CLS_W-1:0] cls);
    return cls == CLS_STRONG;
  endfunction

endpackage

/* rtl/hth_line_store.sv */
// two line stores of class codes in one synchronous memory, word = {far, near}
// registered read, write-to-read forwarding; uses hth_pkg
module hth_line_store #(
  parameter int DEPTH  = hth_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [ADDR_W-1:0]             rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [ADDR_W-1:0]             wr_addr_i,
  input  logic [hth_pkg::LS_WORD_W-1:0] wr_data_i,
  output logic [hth_pkg::LS_WORD_W-1:0] rd_data_o
);
  import hth_pkg::*;

  logic [LS_WORD_W-1:0] mem_q [DEPTH];
  logic [LS_WORD_W-1:0] rd_q;
  logic [LS_WORD_W-1:0] fwd_data_q;
  logic                 fwd_q;

  // memory port: read sees the old word when the same entry is written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // catch a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

/* rtl/hth_window.sv */
// 3x3 window of class codes and the hysteresis decision for its centre
// uses hth_pkg; reads and writes back through hth_line_store
module hth_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  input  hth_pkg::s1_ctrl_t             s1_ctrl_i,
  input  logic [hth_pkg::CLS_W-1:0]     s1_cls_i,
  input  logic [hth_pkg::LS_WORD_W-1:0] rd_data_i,
  output logic [hth_pkg::LS_WORD_W-1:0] wr_data_o,
  output logic                          push_o,
  output hth_pkg::result_t              res_o
);
  import hth_pkg::*;

  // window index is col * 3 + row, col 0 left, row 0 top
  logic [CLS_W-1:0] win_q [9];
  logic [CLS_W-1:0] far_cls, near_cls, centre;
  logic             any_left, any_mid, any_right, any_strong;

  assign far_cls  = rd_data_i[LS_WORD_W-1:CLS_W];
  assign near_cls = rd_data_i[CLS_W-1:0];

  // write back: far takes near, near takes the new class
  assign wr_data_o = {near_cls, s1_cls_i};

  // shift one column in per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= CLS_NONE;
      end
    end else if (s1_valid_i) begin
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= win_q[k+3];
      end
      win_q[6] <= far_cls;
      win_q[7] <= near_cls;
      win_q[8] <= s1_cls_i;
    end
  end

  // neighbours of the centre after the shift, masked at the frame border
  always_comb begin
    centre    = win_q[7];
    any_left  = !s1_ctrl_i.col_first &&
                ((!s1_ctrl_i.row_first && is_strong(win_q[3])) || is_strong(win_q[4]) ||
                 (!s1_ctrl_i.row_last && is_strong(win_q[5])));
    any_mid   = (!s1_ctrl_i.row_first && is_strong(win_q[6])) ||
                (!s1_ctrl_i.row_last && is_strong(win_q[8]));
    any_right = !s1_ctrl_i.col_last &&
                ((!s1_ctrl_i.row_first && is_strong(far_cls)) || is_strong(near_cls) ||
                 (!s1_ctrl_i.row_last && is_strong(s1_cls_i)));
    any_strong = any_left || any_mid || any_right;
  end

  assign push_o          = s1_valid_i && s1_ctrl_i.emit;
  assign res_o.edge_on   = is_strong(centre) || ((centre == CLS_WEAK) && any_strong);
  assign res_o.frame_end = s1_ctrl_i.row_last && s1_ctrl_i.col_last;

endmodule

/* rtl/hth_out_fifo.sv */
// small result queue that decouples the pipeline from the output stall
// uses hth_pkg and assert_macros.svh
`include "assert_macros.svh"
module hth_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  hth_pkg::result_t                data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output hth_pkg::result_t                data_o,
  output logic [hth_pkg::OUT_CNT_W-1:0]   count_o
);
  import hth_pkg::*;

  result_t              buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] count_q, count_d;
  logic                 pop;

  assign valid_o = count_q != '0;
  assign pop     = pop_i && valid_o;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

  // pointers and fill level
  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + OUT_CNT_W'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_IMPLIES(a_push_room, push_i, (count_q < OUT_CNT_W'(OUT_DEPTH)) || pop, "push into full queue")
  `ASSERT_NEXT(a_head_holds, valid_o && !pop_i, $stable(data_o), "queue head changed while stalled")

endmodule

/* rtl/hysteresis_threshold_3x3.sv */
// top level of the 3x3 hysteresis edge marker
// uses hth_pkg, hth_line_store, hth_window, hth_out_fifo, assert_macros.svh
//
// Usage:
//   s_axis carries one transaction per pixel in raster order (tdata = pixel,
//   tuser = 1 for a flush tick without data). m_axis carries one result per
//   pixel (tdata bit 0 = edge marked, tlast = last pixel of the frame).
//   cfg writes thresholds and frame size by register index; write only when
//   the block is idle.
//   A pixel's result follows once frame_width + 1 more transactions have been
//   accepted (the one-row window delay); after the frame's last pixel, send
//   frame_width + 1 flush ticks to drain. Flush ticks sent before all pixels
//   of the frame are in are dropped.
//   Throughput: one transaction per cycle while s_axis tready is high.
//   From acceptance of the transaction that completes a window to tvalid,
//   the path is line store read, then window decision into the result queue.
//   Reset clears counters, window and queue; the line store needs no clear,
//   since rows that are not yet written lie outside the frame and are masked.
//   When m_axis stalls, up to four results wait in the queue and s_axis
//   tready drops before it can overflow; nothing is lost.
`include "assert_macros.svh"
module hysteresis_threshold_3x3 #(
  parameter int MAX_WIDTH  = hth_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hth_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hth_pkg::PIXEL_W-1:0]      s_axis_tdata,  // [15:0] pixel
  input  logic                             s_axis_tuser,  // [0] kind
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hth_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [0] edge_on, [7:1] zero
  output logic                             m_axis_tlast,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hth_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hth_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hth_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 4);

  // configuration registers
  logic [PIXEL_W-1:0]   high_thr_q, low_thr_q;
  logic [FWIDTH_W-1:0]  frame_width_q;
  logic [FHEIGHT_W-1:0] frame_height_q;

  // counters of the accept stage
  logic [COL_W-1:0] in_column_q, in_column_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;

  // window stage registers
  logic             s1_valid_q;
  s1_ctrl_t         s1_ctrl_q, s1_ctrl_d;
  logic [CLS_W-1:0] s1_cls_q, cls_d;
  logic [COL_W-1:0] s1_addr_q;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic             accept, draining, step, col0, col_wrap;

  logic [LS_WORD_W-1:0] rd_data, wr_data;
  logic                 push;
  result_t              res, head;
  logic [OUT_CNT_W-1:0] q_count;

  // configuration write port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q     <= HIGH_THR_RST;
      low_thr_q      <= LOW_THR_RST;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HIGH_THR:     high_thr_q     <= cfg_data_i;
        REG_LOW_THR:      low_thr_q      <= cfg_data_i;
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size in use, held to 1..max
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_eff = HGT_W'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = HGT_W'(frame_height_q);
    end
  end

  // accept stage: class, output position flags and counter update
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign draining = 32'(in_row_q) >= 32'(h_eff);
  assign step     = accept && (!s_axis_tuser || draining);
  assign col0     = in_column_q == '0;
  assign col_wrap = (32'(in_column_q) + 32'd1) >= 32'(w_eff);

  always_comb begin
    cls_d = draining ? CLS_NONE : classify(s_axis_tdata, high_thr_q, low_thr_q);

    s1_ctrl_d.emit = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && !col0);
    if (col0) begin
      s1_ctrl_d.col_first = w_eff == WID_W'(1);
      s1_ctrl_d.col_last  = 1'b1;
      s1_ctrl_d.row_first = in_row_q == ROW_W'(2);
      s1_ctrl_d.row_last  = 32'(in_row_q) >= (32'(h_eff) + 32'd1);
    end else begin
      s1_ctrl_d.col_first = in_column_q == COL_W'(1);
      s1_ctrl_d.col_last  = 32'(in_column_q) >= 32'(w_eff);
      s1_ctrl_d.row_first = in_row_q == ROW_W'(1);
      s1_ctrl_d.row_last  = 32'(in_row_q) >= 32'(h_eff);
    end

    if (col_wrap) begin
      in_column_d = '0;
      in_row_d    = in_row_q + ROW_W'(1);
    end else begin
      in_column_d = in_column_q + COL_W'(1);
      in_row_d    = in_row_q;
    end
    // the frame's last result restarts the counters
    if (s1_ctrl_d.emit && s1_ctrl_d.row_last && s1_ctrl_d.col_last) begin
      in_column_d = '0;
      in_row_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_column_q <= '0;
      in_row_q    <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= step;
      if (step) begin
        in_column_q <= in_column_d;
        in_row_q    <= in_row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_ctrl_q <= s1_ctrl_d;
      s1_cls_q  <= cls_d;
      s1_addr_q <= in_column_q;
    end
  end

  // room for every item that may still push a result
  assign s_axis_tready = (32'(q_count) + 32'(s1_valid_q)) <= (OUT_DEPTH - 1);

  hth_line_store #(
    .DEPTH (MAX_WIDTH),
    .ADDR_W(COL_W)
  ) u_line_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (step),
    .rd_addr_i(in_column_q),
    .wr_en_i  (s1_valid_q),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  hth_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s1_valid_i(s1_valid_q),
    .s1_ctrl_i (s1_ctrl_q),
    .s1_cls_i  (s1_cls_q),
    .rd_data_i (rd_data),
    .wr_data_o (wr_data),
    .push_o    (push),
    .res_o     (res)
  );

  hth_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .pop_i  (m_axis_tready),
    .valid_o(m_axis_tvalid),
    .data_o (head),
    .count_o(q_count)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, head.edge_on};
  assign m_axis_tlast = head.frame_end;

  `ASSERT_ALWAYS(a_col_range, 32'(in_column_q) < MAX_WIDTH, "column counter beyond line store")
  `ASSERT_NEXT(a_frame_restart, step && s1_ctrl_d.emit && s1_ctrl_d.row_last && s1_ctrl_d.col_last, (in_column_q == '0) && (in_row_q == '0), "counters not cleared after frame end")
  `ASSERT_NEXT(a_early_flush_dropped, accept && s_axis_tuser && !draining, !s1_valid_q && $stable(in_row_q) && $stable(in_column_q), "early flush tick changed state")

endmodule

/* verif/hysteresis_threshold_3x3_test.sv */
// testbench of hysteresis_threshold_3x3: directed and random pixel frames,
// every result checked against a transaction-level model of the 3x3 marking
// depends on hth_pkg and the hysteresis_threshold_3x3 rtl
module hysteresis_threshold_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hth_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 400000;

  // item kinds carried in s_axis_tuser
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // receiver stall patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_COMB   = 3;

  // small frame with strong, weak, none and the threshold boundaries
  localparam logic [PIXEL_W-1:0] DIRECTED_PIXELS [12] = '{
    16'd65535, 16'd20001, 16'd0,     16'd20000,
    16'd30000, 16'd40000, 16'd19999, 16'd25000,
    16'd40001, 16'd0,     16'd30000, 16'd65534
  };

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel;
  } pixel_job_t;

  typedef struct packed {
    logic frame_end;
    logic edge_on;
  } edge_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIXEL_W-1:0]     s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  reg_idx_e               cfg_index_i   = REG_HIGH_THR;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // pending stimulus and outstanding results
  pixel_job_t   pixel_jobs [$];
  edge_result_t edges_due [$];
  pixel_job_t   job;

  // shadow of the configuration registers
  logic [PIXEL_W-1:0]   thr_high   = HIGH_THR_RST;
  logic [PIXEL_W-1:0]   thr_low    = LOW_THR_RST;
  logic [FWIDTH_W-1:0]  width_reg  = FRAME_WIDTH_RST;
  logic [FHEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RST;

  // model state: two rows of class codes, the window and the raster position
  logic [CLS_W-1:0] near_cls [MAX_WIDTH_DEF];
  logic [CLS_W-1:0] far_cls [MAX_WIDTH_DEF];
  logic [CLS_W-1:0] win_cls [9];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  int unsigned items_taken    = 0;
  int unsigned counted_items  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  int          rx_mode        = RX_OPEN;
  int          rx_left        = 0;
  logic        rx_go;
  logic        long_hold      = 1'b0;

  hysteresis_threshold_3x3 u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // advance the model by one accepted transaction, queue the result it causes
  function automatic void predict_edge(input logic kind, input logic [PIXEL_W-1:0] pix);
    int unsigned      w, h, c, orow, ocol;
    int               k, col, row;
    logic [CLS_W-1:0] cls;
    logic             draining, emit, on;
    edge_result_t     res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg);
    draining = (row_pos >= h);
    // flush ticks count only once all pixels of the frame are in
    if (kind == KIND_FLUSH && !draining) return;
    if (draining) begin
      cls = CLS_NONE;
    end else if (pix > thr_high) begin
      cls = CLS_STRONG;
    end else if (pix > thr_low) begin
      cls = CLS_WEAK;
    end else begin
      cls = CLS_NONE;
    end
    // shift a column of far row, near row and new class into the window
    c = col_pos % MAX_WIDTH_DEF;
    for (k = 0; k < 6; k++) win_cls[k] = win_cls[k + 3];
    win_cls[6] = far_cls[c];
    win_cls[7] = near_cls[c];
    win_cls[8] = cls;
    far_cls[c] = near_cls[c];
    near_cls[c] = cls;
    // window centre lags the input by one row and one column
    emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
    ocol = 0;
    orow = 0;
    if (emit) begin
      if (col_pos == 0) begin
        ocol = w - 1;
        orow = row_pos - 2;
      end else begin
        ocol = col_pos - 1;
        orow = row_pos - 1;
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (!emit) return;
    // weak centre is marked by any strong neighbor inside the frame
    on = (win_cls[4] == CLS_STRONG);
    if (win_cls[4] == CLS_WEAK) begin
      for (col = 0; col < 3; col++) begin
        for (row = 0; row < 3; row++) begin
          if (col == 1 && row == 1) continue;
          if ((col == 0 && ocol == 0) || (col == 2 && ocol >= w - 1)) continue;
          if ((row == 0 && orow == 0) || (row == 2 && orow >= h - 1)) continue;
          if (win_cls[col * 3 + row] == CLS_STRONG) on = 1'b1;
        end
      end
    end
    res.edge_on   = on;
    res.frame_end = (orow >= h - 1) && (ocol >= w - 1);
    edges_due.push_back(res);
    if (res.frame_end) begin
      col_pos = 0;
      row_pos = 0;
    end
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return thr_high;
      3: return thr_high + 1'b1;
      4: return thr_low;
      5: return thr_low + 1'b1;
      default: return PIXEL_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic push_job(input logic kind, input logic [PIXEL_W-1:0] pixel);
    pixel_jobs.push_back('{kind: kind, pixel: pixel});
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_quiet();
    while (pixel_jobs.size() != 0 || s_axis_tvalid || edges_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    wait_quiet();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HIGH_THR:     thr_high   = value;
      REG_LOW_THR:      thr_low    = value;
      REG_FRAME_WIDTH:  width_reg  = value[FWIDTH_W-1:0];
      REG_FRAME_HEIGHT: height_reg = value[FHEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [PIXEL_W-1:0] hi, input logic [PIXEL_W-1:0] lo,
                            input int unsigned w, input int unsigned h);
    wait_drained();
    write_reg(REG_HIGH_THR, hi);
    write_reg(REG_LOW_THR, lo);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  // one frame with stray early flushes, a mixed drain and trailing ignored ticks
  task automatic run_frame(input int unsigned w, input int unsigned h, input bit pause_mid);
    int unsigned n;
    @(negedge clk_i);
    for (n = 0; n < w * h; n++) begin
      if ($urandom_range(0, 15) == 0) push_job(KIND_FLUSH, PIXEL_W'($urandom_range(0, 16'hFFFF)));
      if (pause_mid && n == (w * h) / 2) wait_quiet();
      push_job(KIND_PIXEL, pick_pixel());
    end
    for (n = 0; n <= w; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_job(KIND_PIXEL, PIXEL_W'($urandom_range(0, 16'hFFFF)));
      end else begin
        push_job(KIND_FLUSH, PIXEL_W'($urandom_range(0, 16'hFFFF)));
      end
    end
    repeat ($urandom_range(0, 2)) push_job(KIND_FLUSH, PIXEL_W'($urandom_range(0, 16'hFFFF)));
    counted_items += w * h + w + 1;
  endtask

  // stimulus: reset, directed frame, random frames, threshold extremes, then the extreme sizes
  initial begin : stimulus
    int                 i;
    int unsigned        w, h;
    logic [PIXEL_W-1:0] hi, lo;
    for (i = 0; i < MAX_WIDTH_DEF; i++) begin
      near_cls[i] = CLS_NONE;
      far_cls[i]  = CLS_NONE;
    end
    for (i = 0; i < 9; i++) win_cls[i] = CLS_NONE;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frame, early flush inside, a pixel during the drain
    set_config(16'd40000, 16'd20000, 4, 3);
    @(negedge clk_i);
    for (i = 0; i < 12; i++) begin
      if (i == 5) push_job(KIND_FLUSH, 16'hFFFF);
      push_job(KIND_PIXEL, DIRECTED_PIXELS[i]);
    end
    for (i = 0; i < 5; i++) begin
      push_job((i == 1) ? KIND_PIXEL : KIND_FLUSH, (i == 1) ? 16'hFFFF : 16'h0000);
    end
    push_job(KIND_FLUSH, 16'h5A5A);

    // random frames, a new setting for each
    while (counted_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: hi = 16'd0;
        1: hi = 16'hFFFF;
        default: hi = PIXEL_W'($urandom_range(8000, 60000));
      endcase
      case ($urandom_range(0, 7))
        0: lo = 16'd0;
        1: lo = 16'hFFFF;
        2: lo = hi;
        3: lo = PIXEL_W'($urandom_range(hi, 16'hFFFF));
        default: lo = PIXEL_W'($urandom_range(0, hi));
      endcase
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      set_config(hi, lo, w, h);
      run_frame(w, h, $urandom_range(0, 4) == 0);
    end

    // threshold extremes on small frames, then zero width and zero height settings
    set_config(16'hFFFF, 16'h0000, 5, 4);
    run_frame(5, 4, 1'b0);
    set_config(16'h0000, 16'hFFFF, 3, 3);
    run_frame(3, 3, 1'b0);
    set_config(16'd30000, 16'd15000, 0, 4);
    run_frame(1, 4, 1'b0);
    set_config(16'd40000, 16'd10000, 7, 0);
    run_frame(7, 1, 1'b0);

    wait_drained();
    if (mismatch_count == 0 && edges_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // long receiver hold-offs while the sender keeps offering pixels
  initial begin : hold_off
    int n;
    for (n = 0; n < 2; n++) begin
      wait (items_taken >= ((n == 0) ? 500 : 1300));
      @(posedge clk_i);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk_i);
      long_hold <= 1'b0;
    end
  end

  // pixel driver: bursts of transactions with random gaps between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_edge(s_axis_tuser, s_axis_tdata);
        items_taken <= items_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pixel_jobs.size() != 0) begin
          job = pixel_jobs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= job.pixel;
          s_axis_tuser  <= job.kind;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result ready: stall pattern switches between a few modes
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RX_OPEN, RX_COMB);
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   rx_go = 1'b1;
      RX_COIN:   rx_go = ($urandom_range(0, 1) == 1);
      RX_SPARSE: rx_go = ($urandom_range(0, 3) == 0);
      default:   rx_go = ((rx_left % 5) < 3);
    endcase
    m_axis_tready <= rx_go && !long_hold;
  end

  // result monitor: compare each transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (edges_due.size() == 0) begin
        $error("result with none expected: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        if (m_axis_tdata[0] !== edges_due[0].edge_on) begin
          $error("edge_on: expected %0b, actual %0b", edges_due[0].edge_on, m_axis_tdata[0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== edges_due[0].frame_end) begin
          $error("frame_end: expected %0b, actual %0b", edges_due[0].frame_end, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:1] !== '0) begin
          $error("tdata padding: expected 0, actual %0h", m_axis_tdata[OUT_TDATA_W-1:1]);
          mismatch_count++;
        end
        void'(edges_due.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

/* hysteresis_threshold_3x3.f */
+incdir+rtl
rtl/hth_pkg.sv
rtl/hth_line_store.sv
rtl/hth_window.sv
rtl/hth_out_fifo.sv
rtl/hysteresis_threshold_3x3.sv
verif/hysteresis_threshold_3x3_test.sv
